### hdl/assert_macros.svh
// Assertion macros used by the RTL of the Bezier flattener.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcf assertion failed");

`endif

### hdl/bcf_pkg.sv
// Types, constants and the interpolation functions of the Bezier flattener.
package bcf_pkg;

  localparam int STEPS      = 25;
  localparam int COORD_BITS = 16;

  localparam int K_W    = $clog2(STEPS + 1);
  localparam int REM_W  = (STEPS > 2) ? $clog2(STEPS) : 1;
  localparam int T_W    = 16;
  localparam int PROD_W = COORD_BITS + 18;

  // curve kind carried on the mode field
  localparam logic MODE_QUAD  = 1'b0;
  localparam logic MODE_CUBIC = 1'b1;

  // t advances by 65536/STEPS per step; the remainder carries the fraction.
  localparam int T_ONE      = 65536;
  localparam int T_STEP_Q   = T_ONE / STEPS;
  localparam int T_STEP_R   = T_ONE % STEPS;
  localparam int T_FIRST_Q  = (T_ONE + STEPS / 2) / STEPS;
  localparam int T_FIRST_R  = (T_ONE + STEPS / 2) % STEPS;
  localparam int ROUND_HALF = 32768;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [T_W-1:0]               t_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // First interpolation level: three lerps per axis.
  typedef struct packed {
    logic cubic;
    logic first;
    logic last;
    pt_t  start;
    pt_t  fin;
    t_t   t;
    pt_t  a;
    pt_t  b;
    pt_t  c;
  } lvl1_t;

  // Second interpolation level: two lerps per axis.
  typedef struct packed {
    logic cubic;
    logic first;
    logic last;
    pt_t  start;
    pt_t  fin;
    t_t   t;
    pt_t  a;
    pt_t  b;
  } lvl2_t;

  // a + floor(((b - a) * t + 32768) / 65536); result always lies between a and b.
  function automatic coord_t lerp(input coord_t a, input coord_t b, input t_t t);
    logic signed [COORD_BITS:0] d;
    logic signed [PROD_W-1:0]   p;
    d = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(a);
    p = PROD_W'(d) * PROD_W'($signed({1'b0, t})) + PROD_W'(ROUND_HALF);
    return coord_t'(a + p[16 +: COORD_BITS]);
  endfunction

  function automatic pt_t lerp_pt(input pt_t a, input pt_t b, input t_t t);
    pt_t r;
    r.x = lerp(a.x, b.x, t);
    r.y = lerp(a.y, b.y, t);
    return r;
  endfunction

endpackage

### hdl/bezier_curve_flattener_unit.sv
// Bezier curve flattener: de Casteljau evaluation at uniform steps, pipelined.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | mode, start, ctrl1, ctrl2, end points
//  out_    | output    | out_valid / out_ready | segment start, segment end, last flag
//
// One curve gives STEPS (25) segments, one issued per cycle unless out_ready stalls;
// the next curve waits until the issue-stage segment counter reaches STEPS.
// The next curve is taken in the cycle the current one issues its last step.
// A step passes from the issue stage through the two interpolation levels (s1_r, s2_r)
// into the output register, which holds the third level, and is then offered on out_;
// the first segment of a curve takes the same path from the curve's transfer.
// A stall on out_ready freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits, the counter and the previous point.
`include "assert_macros.svh"

module bezier_curve_flattener_unit import bcf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_mode,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_ctrl1_x,
  input  coord_t in_ctrl1_y,
  input  coord_t in_ctrl2_x,
  input  coord_t in_ctrl2_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_seg_start_x,
  output coord_t out_seg_start_y,
  output coord_t out_seg_end_x,
  output coord_t out_seg_end_y,
  output logic   out_last_segment
);

  // issue stage
  logic             cur_valid_r, cur_valid_nxt;
  logic             cur_cubic_r, cur_cubic_nxt;
  pt_t              cur_p0_r, cur_p0_nxt;
  pt_t              cur_p1_r, cur_p1_nxt;
  pt_t              cur_p2_r, cur_p2_nxt;
  pt_t              cur_p3_r, cur_p3_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  t_t               t_r, t_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  // interpolation stages
  logic  s1_valid_r, s2_valid_r;
  lvl1_t s1_r, s1_nxt;
  lvl2_t s2_r, s2_nxt;

  // output register
  logic out_valid_r;
  pt_t  out_start_r, out_start_nxt;
  pt_t  out_end_r, out_end_nxt;
  logic out_last_r;
  pt_t  prev_r;

  logic             adv;
  logic             in_xfer;
  logic             k_last;
  logic             issue_last;
  logic [REM_W:0]   rem_sum;
  logic             rem_wrap;
  pt_t              q1_end;
  pt_t              lvl3_pt;

  assign adv        = !out_valid_r || out_ready;
  assign k_last     = (k_r == K_W'(STEPS));
  assign issue_last = adv && cur_valid_r && k_last;
  assign in_ready   = !cur_valid_r || issue_last;
  assign in_xfer    = in_valid && in_ready;

  assign rem_sum  = (REM_W+1)'(rem_r) + (REM_W+1)'(T_STEP_R);
  assign rem_wrap = (rem_sum >= (REM_W+1)'(STEPS));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_cubic_nxt = cur_cubic_r;
    cur_p0_nxt    = cur_p0_r;
    cur_p1_nxt    = cur_p1_r;
    cur_p2_nxt    = cur_p2_r;
    cur_p3_nxt    = cur_p3_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    if (in_xfer) begin
      cur_valid_nxt = 1'b1;
      cur_cubic_nxt = (in_mode == MODE_CUBIC);
      cur_p0_nxt    = '{x: in_start_x, y: in_start_y};
      cur_p1_nxt    = '{x: in_ctrl1_x, y: in_ctrl1_y};
      cur_p2_nxt    = '{x: in_ctrl2_x, y: in_ctrl2_y};
      cur_p3_nxt    = '{x: in_end_x, y: in_end_y};
      k_nxt         = K_W'(1);
      t_nxt         = t_t'(T_FIRST_Q);
      rem_nxt       = REM_W'(T_FIRST_R);
    end else if (issue_last) begin
      cur_valid_nxt = 1'b0;
    end else if (adv && cur_valid_r) begin
      // advance t by one step, carrying the fractional remainder
      k_nxt   = k_r + K_W'(1);
      t_nxt   = t_r + t_t'(T_STEP_Q) + t_t'(rem_wrap);
      rem_nxt = rem_wrap ? REM_W'(rem_sum - (REM_W+1)'(STEPS)) : REM_W'(rem_sum);
    end
  end

  // first level: quadratic pairs (p0,p1) and (p1,end); cubic uses (p1,p2) and adds (p2,end)
  always_comb begin
    q1_end       = cur_cubic_r ? cur_p2_r : cur_p3_r;
    s1_nxt.cubic = cur_cubic_r;
    s1_nxt.first = (k_r == K_W'(1));
    s1_nxt.last  = k_last;
    s1_nxt.start = cur_p0_r;
    s1_nxt.fin   = cur_p3_r;
    s1_nxt.t     = t_r;
    s1_nxt.a     = lerp_pt(cur_p0_r, cur_p1_r, t_r);
    s1_nxt.b     = lerp_pt(cur_p1_r, q1_end, t_r);
    s1_nxt.c     = lerp_pt(cur_p2_r, cur_p3_r, t_r);
  end

  always_comb begin
    s2_nxt.cubic = s1_r.cubic;
    s2_nxt.first = s1_r.first;
    s2_nxt.last  = s1_r.last;
    s2_nxt.start = s1_r.start;
    s2_nxt.fin   = s1_r.fin;
    s2_nxt.t     = s1_r.t;
    s2_nxt.a     = lerp_pt(s1_r.a, s1_r.b, s1_r.t);
    s2_nxt.b     = lerp_pt(s1_r.b, s1_r.c, s1_r.t);
  end

  // third level for cubic; a quadratic point is already complete
  always_comb begin
    lvl3_pt       = s2_r.cubic ? lerp_pt(s2_r.a, s2_r.b, s2_r.t) : s2_r.a;
    out_end_nxt   = s2_r.last ? s2_r.fin : lvl3_pt;
    out_start_nxt = s2_r.first ? s2_r.start : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= '0;
      t_r         <= '0;
      rem_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      k_r         <= k_nxt;
      t_r         <= t_nxt;
      rem_r       <= rem_nxt;
      if (adv) begin
        s1_valid_r  <= cur_valid_r;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
        if (s2_valid_r) begin
          prev_r <= out_end_nxt;
        end
      end
    end
  end

  // payload: no reset; curve points load on transfer, stage registers on advance
  always_ff @(posedge clk) begin
    cur_cubic_r <= cur_cubic_nxt;
    cur_p0_r    <= cur_p0_nxt;
    cur_p1_r    <= cur_p1_nxt;
    cur_p2_r    <= cur_p2_nxt;
    cur_p3_r    <= cur_p3_nxt;
    if (adv) begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      out_start_r <= out_start_nxt;
      out_end_r   <= out_end_nxt;
      out_last_r  <= s2_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seg_start_x  = out_start_r.x;
  assign out_seg_start_y  = out_start_r.y;
  assign out_seg_end_x    = out_end_r.x;
  assign out_seg_end_y    = out_end_r.y;
  assign out_last_segment = out_last_r;

  `BCF_ASSERT_IMPL(a_step_range, cur_valid_r, (k_r != '0) && (k_r <= K_W'(STEPS)))
  `BCF_ASSERT_NEXT(a_curve_load, in_xfer, cur_valid_r && (k_r == K_W'(1)))
  `BCF_ASSERT_NEXT(a_curve_done, issue_last && !in_xfer, !cur_valid_r)

endmodule

### sim/bezier_curve_flattener_unit_tb.sv
// Self-checking testbench for the Bezier curve flattener: directed curves, then random curves.
module bezier_curve_flattener_unit_tb import bcf_pkg::*; ();

  localparam coord_t XMIN = 16'sh8000;
  localparam coord_t XMAX = 16'sh7fff;

  localparam int DIRECTED_ROWS = 16;
  localparam int RANDOM_CURVES = 316;
  localparam int CALM_FIRST    = 100;
  localparam int CALM_LAST     = 160;
  localparam int DRAIN_AT      = 220;
  localparam int IDLE_PCT      = 24;
  localparam int TAIL_CYCLES   = 30;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic   mode;
    coord_t sx;
    coord_t sy;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
    coord_t ex;
    coord_t ey;
  } curve_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } segment_t;

  // rows whose used points all coincide carry the point itself as the expected result
  typedef struct packed {
    curve_t crv;
    logic   typed;
    coord_t at_x;
    coord_t at_y;
  } plan_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_mode = MODE_QUAD;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_ctrl1_x = '0;
  coord_t in_ctrl1_y = '0;
  coord_t in_ctrl2_x = '0;
  coord_t in_ctrl2_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_seg_start_x;
  coord_t out_seg_start_y;
  coord_t out_seg_end_x;
  coord_t out_seg_end_y;
  logic   out_last_segment;

  segment_t  pending_segments[$];
  plan_row_t curve_plan[DIRECTED_ROWS];
  int        fail_count = 0;
  int        cycle_count = 0;
  logic      calm = 1'b0;

  bezier_curve_flattener_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_ctrl1_x      (in_ctrl1_x),
    .in_ctrl1_y      (in_ctrl1_y),
    .in_ctrl2_x      (in_ctrl2_x),
    .in_ctrl2_y      (in_ctrl2_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_start_x (out_seg_start_x),
    .out_seg_start_y (out_seg_start_y),
    .out_seg_end_x   (out_seg_end_x),
    .out_seg_end_y   (out_seg_end_y),
    .out_last_segment(out_last_segment)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // a + floor(((b - a) * t + half) / 65536); arithmetic shift gives the floor
  function automatic coord_t interp(input coord_t a, input coord_t b, input int unsigned t);
    longint d;
    longint p;
    d = longint'(b) - longint'(a);
    p = d * longint'(t) + 64'sd32768;
    return coord_t'(longint'(a) + (p >>> 16));
  endfunction

  function automatic coord_t quad_point(input coord_t p0, input coord_t p1, input coord_t p2,
                                        input int unsigned t);
    return interp(interp(p0, p1, t), interp(p1, p2, t), t);
  endfunction

  function automatic coord_t cubic_point(input coord_t p0, input coord_t p1, input coord_t p2,
                                         input coord_t p3, input int unsigned t);
    return quad_point(interp(p0, p1, t), interp(p1, p2, t), interp(p2, p3, t), t);
  endfunction

  // flatten one curve into STEPS segments and queue them
  task automatic flatten_curve(input curve_t c);
    segment_t    seg;
    coord_t      px;
    coord_t      py;
    coord_t      nx;
    coord_t      ny;
    int unsigned t;
    px = c.sx;
    py = c.sy;
    for (int k = 1; k <= STEPS; k++) begin
      if (k == STEPS) begin
        nx = c.ex;
        ny = c.ey;
      end else begin
        t = (k * 65536 + STEPS / 2) / STEPS;
        if (c.mode == MODE_CUBIC) begin
          nx = cubic_point(c.sx, c.c1x, c.c2x, c.ex, t);
          ny = cubic_point(c.sy, c.c1y, c.c2y, c.ey, t);
        end else begin
          nx = quad_point(c.sx, c.c1x, c.ex, t);
          ny = quad_point(c.sy, c.c1y, c.ey, t);
        end
      end
      seg.sx   = px;
      seg.sy   = py;
      seg.ex   = nx;
      seg.ey   = ny;
      seg.last = (k == STEPS);
      pending_segments.insert(pending_segments.size(), seg);
      px = nx;
      py = ny;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic coord_t pick_coord();
    unique case ($urandom_range(0, 9))
      0: return XMIN;
      1: return XMAX;
      2, 3: return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    coord_t px;
    coord_t py;
    c.mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      // degenerate: every point coincides
      px = pick_coord();
      py = pick_coord();
      c.sx = px; c.c1x = px; c.c2x = px; c.ex = px;
      c.sy = py; c.c1y = py; c.c2y = py; c.ey = py;
    end else begin
      c.sx  = pick_coord();
      c.sy  = pick_coord();
      c.c1x = pick_coord();
      c.c1y = pick_coord();
      c.c2x = pick_coord();
      c.c2y = pick_coord();
      c.ex  = pick_coord();
      c.ey  = pick_coord();
    end
    return c;
  endfunction

  // hold the curve until transferred, queue its segments, then maybe idle
  task automatic send_curve(input curve_t c, input logic typed, input coord_t at_x,
                            input coord_t at_y);
    segment_t seg;
    int       gap;
    in_valid   <= 1'b1;
    in_mode    <= c.mode;
    in_start_x <= c.sx;
    in_start_y <= c.sy;
    in_ctrl1_x <= c.c1x;
    in_ctrl1_y <= c.c1y;
    in_ctrl2_x <= c.c2x;
    in_ctrl2_y <= c.c2y;
    in_end_x   <= c.ex;
    in_end_y   <= c.ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      for (int k = 1; k <= STEPS; k++) begin
        seg = '{at_x, at_y, at_x, at_y, k == STEPS};
        pending_segments.insert(pending_segments.size(), seg);
      end
    end else begin
      flatten_curve(c);
    end
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_segments
    segment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        flag_mismatch("segment with none expected");
      end else begin
        want = pending_segments.pop_front();
        check_field("seg_start_x", out_seg_start_x, want.sx);
        check_field("seg_start_y", out_seg_start_y, want.sy);
        check_field("seg_end_x", out_seg_end_x, want.ex);
        check_field("seg_end_y", out_seg_end_y, want.ey);
        check_field("last_segment", 16'(out_last_segment), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    curve_plan = '{
      '{'{MODE_QUAD, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0},
      '{'{MODE_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0},
      '{'{MODE_CUBIC, XMIN, XMIN, XMIN, XMIN, XMIN, XMIN, XMIN, XMIN}, 1'b1, XMIN, XMIN},
      '{'{MODE_CUBIC, XMAX, XMAX, XMAX, XMAX, XMAX, XMAX, XMAX, XMAX}, 1'b1, XMAX, XMAX},
      // quadratic: second control point must have no effect
      '{'{MODE_QUAD, XMAX, XMIN, XMAX, XMIN, 12345, -12345, XMAX, XMIN}, 1'b1, XMAX, XMIN},
      '{'{MODE_CUBIC, 7, 7, 7, 7, 7, 7, 7, 7}, 1'b1, 7, 7},
      '{'{MODE_CUBIC, XMIN, XMIN, XMAX, XMAX, XMIN, XMIN, XMAX, XMAX}, 1'b0, 0, 0},
      '{'{MODE_CUBIC, XMAX, XMIN, XMIN, XMAX, XMAX, XMIN, XMIN, XMAX}, 1'b0, 0, 0},
      '{'{MODE_QUAD, XMIN, XMIN, XMAX, XMAX, 0, 0, XMIN, XMIN}, 1'b0, 0, 0},
      '{'{MODE_QUAD, XMIN, XMIN, XMAX, XMAX, XMAX, XMIN, XMIN, XMIN}, 1'b0, 0, 0},
      '{'{MODE_QUAD, 0, 0, 160, 0, 0, 0, 160, 160}, 1'b0, 0, 0},
      '{'{MODE_CUBIC, 0, 0, 16, 0, 16, 16, 0, 16}, 1'b0, 0, 0},
      '{'{MODE_CUBIC, 1, -1, -1, 1, 1, -1, -1, 1}, 1'b0, 0, 0},
      '{'{MODE_QUAD, -100, 50, 300, -700, 5, 5, -100, 50}, 1'b0, 0, 0},
      '{'{MODE_CUBIC, XMIN, 0, 0, XMAX, 0, XMIN, XMAX, 0}, 1'b0, 0, 0},
      '{'{MODE_QUAD, XMAX, XMAX, XMIN, XMIN, 1, 1, XMAX, XMAX}, 1'b0, 0, 0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (curve_plan[i])
      send_curve(curve_plan[i].crv, curve_plan[i].typed, curve_plan[i].at_x,
                 curve_plan[i].at_y);
    await_drain();

    for (int n = 0; n < RANDOM_CURVES; n++) begin
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      if (n == DRAIN_AT) await_drain();
      send_curve(random_curve(), 1'b0, '0, '0);
    end

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
